@@ rtl/jed_pkg.sv @@
// ----------------------------------------------------------------------------
// jed_pkg
// Shared types and constants for the 7-bit JIS to EUC decoder.
// ----------------------------------------------------------------------------
package jed_pkg;

    // control characters, compared against the 7-bit stripped byte
    localparam logic [6:0] CH_ESC    = 7'h1B;
    localparam logic [6:0] CH_DOLLAR = 7'h24;
    localparam logic [6:0] CH_PAREN  = 7'h28;
    localparam logic [6:0] CH_SO     = 7'h0E;
    localparam logic [6:0] CH_SI     = 7'h0F;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_DEL    = 7'h7F;
    localparam logic [7:0] CH_SS2    = 8'h8E;

    // configuration register indexes
    localparam logic [1:0] CFG_CONVERT_ENABLE = 2'd0;
    localparam logic [1:0] CFG_KANJI_FINAL    = 2'd1;
    localparam logic [1:0] CFG_ASCII_FINAL    = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd3;

    // input mode
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // shift sets
    localparam logic SET_G0 = 1'b0;
    localparam logic SET_G1 = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_ESC,
        ST_ESC_KI,
        ST_ESC_KO,
        ST_SI,
        ST_SO
    } dec_state_t;

    // up to three output bytes caused by one input; count 0 means none
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } burst_t;

endpackage

@@ rtl/jed_front.sv @@
// ----------------------------------------------------------------------------
// jed_front
// Accepts bytes and ticks, runs the escape/shift decoder and pushes the
// resulting byte burst into the queue. Holds the configuration registers.
// ----------------------------------------------------------------------------
module jed_front
    import jed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_mode,
    input  logic [7:0] item_byte,
    input  logic       queue_full,
    output logic       item_ready,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       push,
    output burst_t     push_burst
);

    logic       convert_enable_reg;
    logic [6:0] kanji_final_reg;
    logic [6:0] ascii_final_reg;
    logic [7:0] timeout_ticks_reg;

    dec_state_t state_reg, state_next;
    logic       shift_set_reg, shift_set_next;
    logic       saved_set_reg, saved_set_next;
    logic       g0_kanji_reg, g0_kanji_next;
    logic [7:0] lead_byte_reg, lead_byte_next;
    logic       timer_armed_reg, timer_armed_next;
    logic [7:0] timer_count_reg, timer_count_next;

    logic       accept;
    logic [6:0] c;
    logic [7:0] tick_count;
    dec_state_t st;
    burst_t     burst;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign c          = item_byte[6:0];
    assign tick_count = (timer_count_reg == 8'hFF) ? timer_count_reg
                                                   : timer_count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            convert_enable_reg <= 1'b1;
            kanji_final_reg    <= 7'd66;
            ascii_final_reg    <= 7'd74;
            timeout_ticks_reg  <= 8'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CONVERT_ENABLE: convert_enable_reg <= cfg_data[0];
                CFG_KANJI_FINAL:    kanji_final_reg    <= cfg_data[6:0];
                CFG_ASCII_FINAL:    ascii_final_reg    <= cfg_data[6:0];
                CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            shift_set_reg   <= SET_G0;
            saved_set_reg   <= SET_G0;
            g0_kanji_reg    <= 1'b0;
            lead_byte_reg   <= 8'd0;
            timer_armed_reg <= 1'b0;
            timer_count_reg <= 8'd0;
        end
        else
        begin
            state_reg       <= state_next;
            shift_set_reg   <= shift_set_next;
            saved_set_reg   <= saved_set_next;
            g0_kanji_reg    <= g0_kanji_next;
            lead_byte_reg   <= lead_byte_next;
            timer_armed_reg <= timer_armed_next;
            timer_count_reg <= timer_count_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        shift_set_next   = shift_set_reg;
        saved_set_next   = saved_set_reg;
        g0_kanji_next    = g0_kanji_reg;
        lead_byte_next   = lead_byte_reg;
        timer_armed_next = timer_armed_reg;
        timer_count_next = timer_count_reg;
        st               = state_reg;
        burst            = '0;

        if (accept)
        begin
            if (item_mode == MODE_TICK)
            begin
                if (timer_armed_reg)
                begin
                    if (tick_count < timeout_ticks_reg)
                    begin
                        timer_count_next = tick_count;
                    end
                    else
                    begin
                        // expired: emit the pending control raw
                        timer_armed_next = 1'b0;
                        timer_count_next = 8'd0;
                        state_next       = ST_IDLE;
                        case (state_reg)
                            ST_ESC:
                            begin
                                burst.count    = 2'd1;
                                burst.bytes[0] = {1'b0, CH_ESC};
                            end
                            ST_SI:
                            begin
                                burst.count    = 2'd1;
                                burst.bytes[0] = {1'b0, CH_SI};
                                shift_set_next = saved_set_reg;
                            end
                            ST_SO:
                            begin
                                burst.count    = 2'd1;
                                burst.bytes[0] = {1'b0, CH_SO};
                                shift_set_next = saved_set_reg;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            else if (!convert_enable_reg)
            begin
                burst.count    = 2'd1;
                burst.bytes[0] = item_byte;
            end
            else
            begin
                // a byte after a lone SI or SO decodes as idle
                if (state_reg == ST_SI || state_reg == ST_SO)
                begin
                    timer_armed_next = 1'b0;
                    timer_count_next = 8'd0;
                    st               = ST_IDLE;
                end
                state_next = ST_IDLE;
                case (st)
                    ST_LEAD:
                    begin
                        burst.count    = 2'd2;
                        burst.bytes[0] = lead_byte_reg;
                        burst.bytes[1] = {1'b1, c};
                    end
                    ST_ESC_KI:
                    begin
                        if (c == kanji_final_reg)
                        begin
                            g0_kanji_next = 1'b1;
                        end
                        else
                        begin
                            burst.count    = 2'd3;
                            burst.bytes[0] = {1'b0, CH_ESC};
                            burst.bytes[1] = {1'b0, CH_DOLLAR};
                            burst.bytes[2] = {1'b0, c};
                        end
                    end
                    ST_ESC_KO:
                    begin
                        if (c == ascii_final_reg)
                        begin
                            g0_kanji_next = 1'b0;
                        end
                        else
                        begin
                            burst.count    = 2'd3;
                            burst.bytes[0] = {1'b0, CH_ESC};
                            burst.bytes[1] = {1'b0, CH_PAREN};
                            burst.bytes[2] = {1'b0, c};
                        end
                    end
                    ST_ESC:
                    begin
                        timer_armed_next = 1'b0;
                        timer_count_next = 8'd0;
                        if (c == CH_DOLLAR)
                        begin
                            state_next = ST_ESC_KI;
                        end
                        else if (c == CH_PAREN)
                        begin
                            state_next = ST_ESC_KO;
                        end
                        else
                        begin
                            burst.count    = 2'd2;
                            burst.bytes[0] = {1'b0, CH_ESC};
                            burst.bytes[1] = {1'b0, c};
                        end
                    end
                    default:
                    begin
                        if (c == CH_ESC)
                        begin
                            state_next       = ST_ESC;
                            timer_armed_next = 1'b1;
                            timer_count_next = 8'd0;
                        end
                        else if (c == CH_SI || c == CH_SO)
                        begin
                            state_next       = (c == CH_SI) ? ST_SI : ST_SO;
                            saved_set_next   = shift_set_reg;
                            shift_set_next   = (c == CH_SI) ? SET_G0 : SET_G1;
                            timer_armed_next = 1'b1;
                            timer_count_next = 8'd0;
                        end
                        else if (c <= CH_SPACE || c == CH_DEL)
                        begin
                            burst.count    = 2'd1;
                            burst.bytes[0] = {1'b0, c};
                        end
                        else if (shift_set_reg == SET_G0)
                        begin
                            if (!g0_kanji_reg)
                            begin
                                burst.count    = 2'd1;
                                burst.bytes[0] = {1'b0, c};
                            end
                            else
                            begin
                                // hold the lead byte until its trail arrives
                                lead_byte_next = {1'b1, c};
                                state_next     = ST_LEAD;
                            end
                        end
                        else
                        begin
                            burst.count    = 2'd2;
                            burst.bytes[0] = CH_SS2;
                            burst.bytes[1] = {1'b1, c};
                        end
                    end
                endcase
            end
        end
    end

    assign push       = accept && (burst.count != 2'd0);
    assign push_burst = burst;

endmodule

@@ rtl/jed_queue.sv @@
// ----------------------------------------------------------------------------
// jed_queue
// Small FIFO of byte bursts between the decoder and the output stage.
// ----------------------------------------------------------------------------
module jed_queue
    import jed_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_burst,
    input  logic   pop,
    output burst_t head,
    output logic   empty,
    output logic   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    burst_t           entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_burst;
        end
    end

endmodule

@@ rtl/jed_back.sv @@
// ----------------------------------------------------------------------------
// jed_back
// Unpacks queued bursts into single output bytes, one per cycle unless
// out_ready stalls, through an output register; marks each burst's last byte.
// ----------------------------------------------------------------------------
module jed_back
    import jed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  burst_t     head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       head_last;

    assign load      = !valid_reg || out_ready;
    assign head_last = (idx_reg == head.count - 2'd1);

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                byte_next = head.bytes[idx_reg];
                last_next = head_last;
                if (head_last)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

@@ rtl/jis7_to_euc_decoder_core.sv @@
// ----------------------------------------------------------------------------
// jis7_to_euc_decoder_core
// 7-bit JIS terminal stream to EUC decoder, stream in and stream out.
// ----------------------------------------------------------------------------
// Each input request is a received byte (s_tuser = 0) or one timer tick
// (s_tuser = 1). The decoder takes one request per cycle as long as the burst
// queue (QUEUE_DEPTH entries) has room; every request yields zero to three
// output bytes, which leave one per cycle while m_tready is high, through a
// registered output, with m_tlast on the final byte of each request.
// Single-byte results therefore sustain one request per cycle, while SS2
// kana pairs, Kanji pairs and passed-through escapes put two or three bytes
// into the output, absorbed by the queue. Configuration writes are accepted
// every cycle and should be issued only while the decoder is idle.
module jis7_to_euc_decoder_core
    import jed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic   push;
    burst_t push_burst;
    logic   pop;
    burst_t head;
    logic   empty;
    logic   full;

    assign cfg_ready = 1'b1;

    jed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_mode  (s_tuser),
        .item_byte  (s_tdata),
        .queue_full (full),
        .item_ready (s_tready),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_burst (push_burst)
    );

    jed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_burst (push_burst),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jed_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ rtl/jed_checker.sv @@
// ----------------------------------------------------------------------------
// jed_checker
// Port-level checks on the decoder output stream.
// ----------------------------------------------------------------------------
module jed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // hold a stalled request
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // SS2 or Kanji lead is followed at once by a high-bit final byte
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast && m_tdata[7]
        |=> m_tvalid && m_tdata[7] && m_tlast)
        else $error("multibyte pair not completed");

    // a passed-through escape continues with 7-bit bytes
    a_escape_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast && !m_tdata[7]
        |=> m_tvalid && !m_tdata[7])
        else $error("escape sequence broken");

endmodule

bind jis7_to_euc_decoder_core jed_checker u_jed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/jed_checker.sv @@
// ----------------------------------------------------------------------------
// jed_scoreboard
// Watches the decoder's request, result and register channels, predicts the
// EUC bytes each request must produce and compares them in order.
// ----------------------------------------------------------------------------
module jed_scoreboard
    import jed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         requests_seen,
    output int         bytes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       tail;
    } euc_byte_t;

    euc_byte_t euc_expected[$];

    // register copies
    logic       conv_on;
    logic [6:0] kanji_final;
    logic [6:0] ascii_final;
    logic [7:0] tick_limit;

    // decoder state copies
    dec_state_t dstate;
    logic       shift_g1;
    logic       saved_g1;
    logic       g0_kanji;
    logic [7:0] lead_byte;
    logic       timer_on;
    logic [7:0] timer_cnt;

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch in %s: expected %02h, got %02h",
                     $realtime, what, want, got);
    endtask

    task automatic decode_request(input logic mode, input logic [7:0] raw);
        logic [7:0] outs[$];
        logic [6:0] c;
        c = raw[6:0];
        if (mode == MODE_TICK) begin
            if (timer_on) begin
                if (timer_cnt != 8'hFF)
                    timer_cnt++;
                if (timer_cnt >= tick_limit) begin
                    timer_on  = 1'b0;
                    timer_cnt = '0;
                    case (dstate)
                        ST_ESC: outs.push_back({1'b0, CH_ESC});
                        ST_SI:
                        begin
                            outs.push_back({1'b0, CH_SI});
                            shift_g1 = saved_g1;
                        end
                        ST_SO:
                        begin
                            outs.push_back({1'b0, CH_SO});
                            shift_g1 = saved_g1;
                        end
                        default: ;
                    endcase
                    dstate = ST_IDLE;
                end
            end
        end
        else if (!conv_on) begin
            outs.push_back(raw);
        end
        else begin
            // a byte after a lone shift cancels its timeout
            if (dstate == ST_SI || dstate == ST_SO) begin
                timer_on  = 1'b0;
                timer_cnt = '0;
                dstate    = ST_IDLE;
            end
            case (dstate)
                ST_LEAD:
                begin
                    outs.push_back(lead_byte);
                    outs.push_back({1'b1, c});
                    dstate = ST_IDLE;
                end
                ST_ESC_KI:
                begin
                    if (c == kanji_final)
                        g0_kanji = 1'b1;
                    else begin
                        outs.push_back({1'b0, CH_ESC});
                        outs.push_back({1'b0, CH_DOLLAR});
                        outs.push_back({1'b0, c});
                    end
                    dstate = ST_IDLE;
                end
                ST_ESC_KO:
                begin
                    if (c == ascii_final)
                        g0_kanji = 1'b0;
                    else begin
                        outs.push_back({1'b0, CH_ESC});
                        outs.push_back({1'b0, CH_PAREN});
                        outs.push_back({1'b0, c});
                    end
                    dstate = ST_IDLE;
                end
                ST_ESC:
                begin
                    timer_on  = 1'b0;
                    timer_cnt = '0;
                    if (c == CH_DOLLAR)
                        dstate = ST_ESC_KI;
                    else if (c == CH_PAREN)
                        dstate = ST_ESC_KO;
                    else begin
                        outs.push_back({1'b0, CH_ESC});
                        outs.push_back({1'b0, c});
                        dstate = ST_IDLE;
                    end
                end
                default:
                begin
                    dstate = ST_IDLE;
                    if (c == CH_ESC) begin
                        dstate    = ST_ESC;
                        timer_on  = 1'b1;
                        timer_cnt = '0;
                    end
                    else if (c == CH_SI || c == CH_SO) begin
                        dstate    = (c == CH_SI) ? ST_SI : ST_SO;
                        saved_g1  = shift_g1;
                        shift_g1  = (c == CH_SO) ? SET_G1 : SET_G0;
                        timer_on  = 1'b1;
                        timer_cnt = '0;
                    end
                    else if (c <= CH_SPACE || c == CH_DEL)
                        outs.push_back({1'b0, c});
                    else if (shift_g1 == SET_G0) begin
                        if (!g0_kanji)
                            outs.push_back({1'b0, c});
                        else begin
                            lead_byte = {1'b1, c};
                            dstate    = ST_LEAD;
                        end
                    end
                    else begin
                        outs.push_back(CH_SS2);
                        outs.push_back({1'b1, c});
                    end
                end
            endcase
        end
        foreach (outs[i])
            euc_expected.push_back('{code: outs[i], tail: (i == outs.size() - 1)});
    endtask

    always @(posedge clk or negedge rst_n) begin
        euc_byte_t head;
        if (!rst_n) begin
            euc_expected.delete();
            conv_on       = 1'b1;
            kanji_final   = 7'd66;
            ascii_final   = 7'd74;
            tick_limit    = 8'd8;
            dstate        = ST_IDLE;
            shift_g1      = SET_G0;
            saved_g1      = SET_G0;
            g0_kanji      = 1'b0;
            lead_byte     = '0;
            timer_on      = 1'b0;
            timer_cnt     = '0;
            fail_count    = 0;
            pending       = 0;
            requests_seen = 0;
            bytes_seen    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CONVERT_ENABLE: conv_on     = cfg_data[0];
                    CFG_KANJI_FINAL:    kanji_final = cfg_data[6:0];
                    CFG_ASCII_FINAL:    ascii_final = cfg_data[6:0];
                    CFG_TIMEOUT_TICKS:  tick_limit  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                requests_seen++;
                decode_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                bytes_seen++;
                if (euc_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t unexpected output byte %02h (last %b)",
                                 $realtime, m_tdata, m_tlast);
                end
                else begin
                    head = euc_expected.pop_front();
                    if (m_tdata !== head.code)
                        flag_mismatch("out_byte", head.code, m_tdata);
                    if (m_tlast !== head.tail)
                        flag_mismatch("last", {7'd0, head.tail}, {7'd0, m_tlast});
                end
            end
            pending = euc_expected.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Regression for the 7-bit JIS to EUC decoder: directed escapes, shifts,
// Kanji pairs and timeouts, then random byte streams over five register
// settings with varied back-pressure; results are checked by jed_scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jed_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_SET = 88;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int requests_seen;
    int bytes_seen;

    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    logic hold_req;
    int items_sent;

    logic [6:0] cur_kanji;
    logic [6:0] cur_ascii;
    logic [7:0] cur_timeout;

    int set_convert[5] = '{1, 1, 1, 0, 1};
    int kanji_finals[5] = '{8'h42, 8'h40, 8'h00, 8'h7F, 8'h42};
    int ascii_finals[5] = '{8'h4A, 8'h42, 8'h7F, 8'h00, 8'h4A};
    int set_timeout[5] = '{3, 0, 255, 1, 8};
    int set_send_idle[5] = '{22, 22, 58, 58, 0};
    int set_recv_idle[5] = '{58, 58, 22, 22, 0};

    jis7_to_euc_decoder_core DUT (.*);

    jed_scoreboard u_scoreboard (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic mode, input logic [7:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // random bit 7: the decoder strips it when converting
    task automatic send_char(input logic [6:0] c);
        send_item(MODE_BYTE, {1'($urandom_range(1)), c});
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(MODE_TICK, 8'($urandom));
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input int k);
        drain();
        cur_kanji   = kanji_finals[k][6:0];
        cur_ascii   = ascii_finals[k][6:0];
        cur_timeout = set_timeout[k][7:0];
        write_reg(CFG_CONVERT_ENABLE, set_convert[k][7:0]);
        write_reg(CFG_KANJI_FINAL, {1'b0, cur_kanji});
        write_reg(CFG_ASCII_FINAL, {1'b0, cur_ascii});
        write_reg(CFG_TIMEOUT_TICKS, cur_timeout);
        send_idle_pct = set_send_idle[k];
        recv_idle_pct = set_recv_idle[k];
    endtask

    function automatic logic [6:0] printable();
        return 7'($urandom_range(8'h21, 8'h7E));
    endfunction

    // one well-formed fragment of a JIS stream, or some noise
    task automatic send_fragment();
        int pick;
        int k;
        logic [6:0] lone;
        pick = $urandom_range(99);
        if (pick < 30) begin
            repeat ($urandom_range(1, 4)) send_char(printable());
        end
        else if (pick < 38) begin
            k = $urandom_range(33);
            send_char((k == 33) ? CH_DEL : 7'(k));
        end
        else if (pick < 48) begin
            send_char(CH_ESC);
            send_char(CH_DOLLAR);
            send_char(($urandom_range(9) == 0) ? 7'($urandom) : cur_kanji);
        end
        else if (pick < 56) begin
            send_char(CH_ESC);
            send_char(CH_PAREN);
            send_char(($urandom_range(9) == 0) ? 7'($urandom) : cur_ascii);
        end
        else if (pick < 70) begin
            send_char(CH_SO);
            repeat ($urandom_range(1, 4)) send_char(printable());
            send_char(CH_SI);
        end
        else if (pick < 78) begin
            // lone ESC, SI or SO, left to time out or interrupted early
            k = $urandom_range(2);
            lone = (k == 0) ? CH_ESC : ((k == 1) ? CH_SI : CH_SO);
            send_char(lone);
            if ($urandom_range(3) == 0)
                send_ticks($urandom_range(0, cur_timeout));
            else
                send_ticks(int'(cur_timeout) + $urandom_range(0, 1));
        end
        else if (pick < 84) begin
            send_ticks($urandom_range(1, 4));
        end
        else if (pick < 90) begin
            send_char(CH_ESC);
            send_char(7'($urandom));
        end
        else begin
            send_item(MODE_BYTE, 8'($urandom));
        end
    endtask

    initial begin
        int target;
        int waited;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_BYTE;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_CONVERT_ENABLE;
        cfg_data      = '0;
        hold_req      = 1'b0;
        cycle_count   = 0;
        items_sent    = 0;
        send_idle_pct = 22;
        recv_idle_pct = 58;
        cur_kanji     = 7'h42;
        cur_ascii     = 7'h4A;
        cur_timeout   = 8'd8;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed pass at reset settings
        send_ticks(1);                          // no timer armed
        send_item(MODE_BYTE, 8'hC1);            // high bit stripped
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'h7F);
        send_item(MODE_BYTE, 8'h20);
        send_item(MODE_BYTE, 8'h1B);            // select Kanji into G0
        send_item(MODE_BYTE, 8'h24);
        send_item(MODE_BYTE, 8'h42);
        send_item(MODE_BYTE, 8'h30);            // Kanji pair
        send_item(MODE_BYTE, 8'hA1);
        send_item(MODE_BYTE, 8'h7E);            // control taken as trail byte
        send_item(MODE_BYTE, 8'h0A);
        send_item(MODE_BYTE, 8'h1B);            // back to ASCII
        send_item(MODE_BYTE, 8'h28);
        send_item(MODE_BYTE, 8'h4A);
        send_item(MODE_BYTE, 8'h0E);            // kana through G1
        send_item(MODE_BYTE, 8'h31);
        send_item(MODE_BYTE, 8'h0F);
        send_item(MODE_BYTE, 8'h41);
        send_item(MODE_BYTE, 8'h1B);            // unknown escape finals pass through
        send_item(MODE_BYTE, 8'h24);
        send_item(MODE_BYTE, 8'h41);
        send_item(MODE_BYTE, 8'h9B);
        send_item(MODE_BYTE, 8'h78);
        send_item(MODE_BYTE, 8'h1B);            // lone ESC times out
        send_ticks(8);
        send_item(MODE_BYTE, 8'h0E);            // lone SO times out, set restored
        send_ticks(8);
        send_item(MODE_BYTE, 8'h52);

        for (int k = 0; k < 5; k++) begin
            apply_setting(k);
            target = items_sent + ITEMS_PER_SET;
            if (k == 0) begin
                // long stall on the result side while requests keep coming
                hold_req = 1'b1;
                repeat (40) send_char(printable());
            end
            while (items_sent < target) begin
                send_fragment();
                if (k == 1 && items_sent >= target - ITEMS_PER_SET / 2 && pending != 0
                    && $urandom_range(15) == 0)
                    drain();
            end
        end

        s_tvalid = 1'b0;
        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending != 0)
            $display("%0d expected bytes never arrived", pending);
        $display("covered %0d requests and %0d EUC bytes over five register settings",
                 requests_seen, bytes_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
